>>> rtl/msp_pkg.sv
package msp_pkg;

	// address space width used for the end-of-space check
	localparam int ADDRESS_BITS = 32;

	localparam logic [31:0] MIN_START   = 32'h0010_0000;
	localparam logic [31:0] MIN_GRAIN   = 32'h0000_0100;
	localparam logic [31:0] RESET_GRAIN = 32'h0000_1000;
	localparam logic [15:0] PAT_A       = 16'hAA55;
	localparam logic [15:0] PAT_B       = 16'h55AA;

	// command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_RESP  = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// configuration register indexes
	localparam int          CFG_INDEX_BITS = 2;
	localparam logic [1:0]  REG_START      = 2'd0;
	localparam logic [1:0]  REG_GRAIN      = 2'd1;
	localparam logic [1:0]  REG_KERNEL_END = 2'd2;

	// output queue depth, room for two results per request
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_HEAD_OLD = 7'b0000010,
		PH_HEAD_A   = 7'b0000100,
		PH_HEAD_B   = 7'b0001000,
		PH_TAIL_OLD = 7'b0010000,
		PH_TAIL_A   = 7'b0100000,
		PH_TAIL_B   = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [31:0] start_address;
		logic [31:0] grain_size;
		logic [31:0] kernel_end;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  request_kind;
		logic [31:0] access_address;
		logic [15:0] write_value;
		logic [31:0] usable_start;
		logic [32:0] usable_size;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [1:0] n;
		rsp_t       r0;
		rsp_t       r1;
	} push_t;

endpackage

>>> rtl/msp_core.sv
module msp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 command,
	input  logic [15:0]          read_data,
	input  msp_pkg::cfg_t        cfg,
	output msp_pkg::push_t       push
);

	localparam logic [34:0] SPACE_LIMIT =
		(msp_pkg::ADDRESS_BITS >= 35) ? {35{1'b1}} : (35'd1 << msp_pkg::ADDRESS_BITS);

	msp_pkg::phase_t phase_q, phase_d;
	logic [31:0] start_q, start_d;
	logic [31:0] grain_q, grain_d;
	logic [32:0] size_q, size_d;
	logic [15:0] saved_q, saved_d;

	logic [31:0] start_c, grain_c;
	logic [32:0] size_c;
	logic [33:0] span_c;
	logic [34:0] end_c;
	logic        fits_c;
	logic        tail_pass;
	logic [31:0] head_q, tail_q, cur_addr, head_c;
	logic [1:0]  n_d;
	msp_pkg::rsp_t r0_d, r1_d;

	function automatic msp_pkg::rsp_t rd_rsp(input logic [31:0] addr);
		msp_pkg::rsp_t r;
		r = '0;
		r.request_kind   = msp_pkg::KIND_READ;
		r.access_address = addr;
		return r;
	endfunction

	function automatic msp_pkg::rsp_t wr_rsp(input logic [31:0] addr, input logic [15:0] val);
		msp_pkg::rsp_t r;
		r = '0;
		r.request_kind   = msp_pkg::KIND_WRITE;
		r.access_address = addr;
		r.write_value    = val;
		return r;
	endfunction

	// done report, clipped so usable memory starts no lower than the kernel end
	function automatic msp_pkg::rsp_t done_rsp(input logic [31:0] s, input logic [32:0] z,
			input logic [31:0] kend);
		msp_pkg::rsp_t r;
		logic [31:0] cut;
		r = '0;
		cut = kend - s;
		r.request_kind = msp_pkg::KIND_DONE;
		r.usable_start = s;
		r.usable_size  = z;
		if (s <= kend) begin
			r.usable_start = kend;
			r.usable_size  = (z > {1'b0, cut}) ? (z - {1'b0, cut}) : 33'd0;
		end
		return r;
	endfunction

	// candidate start/grain/size for the next grain check and any report
	always_comb begin
		tail_pass = (phase_q == msp_pkg::PH_TAIL_B) && (read_data == msp_pkg::PAT_B);
		if (command == msp_pkg::CMD_START) begin
			start_c = (cfg.start_address < msp_pkg::MIN_START) ?
				msp_pkg::MIN_START : cfg.start_address;
			grain_c = (cfg.grain_size < msp_pkg::MIN_GRAIN) ?
				msp_pkg::MIN_GRAIN : cfg.grain_size;
			size_c  = '0;
		end else begin
			start_c = start_q;
			grain_c = grain_q;
			size_c  = tail_pass ? (size_q + {1'b0, grain_q}) : size_q;
		end
		span_c = {1'b0, size_c} + {2'b00, grain_c};
		end_c  = {2'b00, size_c} + {3'b000, start_c} + {3'b000, grain_c};
		fits_c = (span_c <= 34'h1_0000_0000) &&
			((msp_pkg::ADDRESS_BITS >= 35) || (end_c <= SPACE_LIMIT));
		head_c = start_c + size_c[31:0];
	end

	assign head_q   = start_q + size_q[31:0];
	assign tail_q   = head_q + grain_q - 32'd2;
	assign cur_addr = (phase_q inside {msp_pkg::PH_TAIL_OLD, msp_pkg::PH_TAIL_A,
		msp_pkg::PH_TAIL_B}) ? tail_q : head_q;

	always_comb begin
		phase_d = phase_q;
		start_d = start_q;
		grain_d = grain_q;
		size_d  = size_q;
		saved_d = saved_q;
		n_d     = 2'd0;
		r0_d    = '0;
		r1_d    = '0;
		if (command == msp_pkg::CMD_START) begin
			start_d = start_c;
			grain_d = grain_c;
			size_d  = '0;
			saved_d = '0;
			n_d     = 2'd1;
			if (fits_c) begin
				phase_d = msp_pkg::PH_HEAD_OLD;
				r0_d    = rd_rsp(head_c);
			end else begin
				phase_d = msp_pkg::PH_IDLE;
				r0_d    = done_rsp(start_c, size_c, cfg.kernel_end);
			end
		end else begin
			case (phase_q)
				msp_pkg::PH_HEAD_OLD, msp_pkg::PH_TAIL_OLD: begin
					saved_d = read_data;
					r0_d    = wr_rsp(cur_addr, msp_pkg::PAT_A);
					r1_d    = rd_rsp(cur_addr);
					n_d     = 2'd2;
					phase_d = (phase_q == msp_pkg::PH_HEAD_OLD) ?
						msp_pkg::PH_HEAD_A : msp_pkg::PH_TAIL_A;
				end
				msp_pkg::PH_HEAD_A, msp_pkg::PH_TAIL_A: begin
					if (read_data != msp_pkg::PAT_A) begin
						r0_d    = done_rsp(start_q, size_q, cfg.kernel_end);
						n_d     = 2'd1;
						phase_d = msp_pkg::PH_IDLE;
					end else begin
						r0_d    = wr_rsp(cur_addr, msp_pkg::PAT_B);
						r1_d    = rd_rsp(cur_addr);
						n_d     = 2'd2;
						phase_d = (phase_q == msp_pkg::PH_HEAD_A) ?
							msp_pkg::PH_HEAD_B : msp_pkg::PH_TAIL_B;
					end
				end
				msp_pkg::PH_HEAD_B: begin
					if (read_data != msp_pkg::PAT_B) begin
						r0_d    = done_rsp(start_q, size_q, cfg.kernel_end);
						n_d     = 2'd1;
						phase_d = msp_pkg::PH_IDLE;
					end else begin
						r0_d    = wr_rsp(cur_addr, saved_q);
						r1_d    = rd_rsp(tail_q);
						n_d     = 2'd2;
						phase_d = msp_pkg::PH_TAIL_OLD;
					end
				end
				msp_pkg::PH_TAIL_B: begin
					if (!tail_pass) begin
						r0_d    = done_rsp(start_q, size_q, cfg.kernel_end);
						n_d     = 2'd1;
						phase_d = msp_pkg::PH_IDLE;
					end else begin
						r0_d   = wr_rsp(cur_addr, saved_q);
						size_d = size_c;
						n_d    = 2'd2;
						if (fits_c) begin
							r1_d    = rd_rsp(head_c);
							phase_d = msp_pkg::PH_HEAD_OLD;
						end else begin
							r1_d    = done_rsp(start_c, size_c, cfg.kernel_end);
							phase_d = msp_pkg::PH_IDLE;
						end
					end
				end
				default: begin
					phase_d = msp_pkg::PH_IDLE;
				end
			endcase
		end
		if (n_d == 2'd1) begin
			r0_d.last = 1'b1;
		end
		if (n_d == 2'd2) begin
			r1_d.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= msp_pkg::PH_IDLE;
			start_q <= '0;
			grain_q <= '0;
			size_q  <= '0;
			saved_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			start_q <= start_d;
			grain_q <= grain_d;
			size_q  <= size_d;
			saved_q <= saved_d;
		end
	end

	assign push.n  = fire ? n_d : 2'd0;
	assign push.r0 = r0_d;
	assign push.r1 = r1_d;

	a_done0_past_kernel: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0 && push.r0.request_kind == msp_pkg::KIND_DONE)
		|-> (push.r0.usable_start >= cfg.kernel_end))
		else $error("done report starts below kernel end");

	a_done1_past_kernel: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2 && push.r1.request_kind == msp_pkg::KIND_DONE)
		|-> (push.r1.usable_start >= cfg.kernel_end))
		else $error("done report starts below kernel end");

endmodule

>>> rtl/msp_outq.sv
module msp_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  msp_pkg::push_t  push,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output msp_pkg::rsp_t   head
);

	localparam int DEPTH = msp_pkg::QUEUE_DEPTH;
	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	msp_pkg::rsp_t entries_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_1;
	logic [CNT_BITS-1:0] count_q;
	logic                pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign room      = (count_q <= CNT_BITS'(DEPTH - 2));
	assign head      = entries_q[rd_ptr_q];
	assign wr_ptr_1  = wr_ptr_q + PTR_BITS'(1);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			entries_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			entries_q[wr_ptr_1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			count_q <= count_q + CNT_BITS'(push.n) - CNT_BITS'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("output queue overfilled");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> ((CNT_BITS + 1)'(count_q) + (CNT_BITS + 1)'(push.n)
		<= (CNT_BITS + 1)'(DEPTH)))
		else $error("push without queue room");

endmodule

>>> rtl/memory_size_probe_sequencer_top.sv
// channel   handshake               payload
// config    cfg_write               cfg_index, cfg_data
// input     in_valid / in_ready     command, read_data
// output    out_valid / out_ready   request_kind, access_address, write_value,
//                                   usable_start, usable_size, last
//
// a request waits in the input register until the output queue has room;
// its results then go into the output queue and are offered from there
// each request makes zero to two results; the single output port drains one
// a cycle while out_ready is high, so a request goes in every cycle while
// the queue has room for two; steady two-result requests outpace the port
// reset clears the probe state, the input register and the output queue, and loads the register defaults
// a stalled output holds requests in the input register; nothing is dropped
module memory_size_probe_sequencer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_write,
	input  logic [msp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [31:0]                         cfg_data,
	// request channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic [15:0]                         read_data,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          request_kind,
	output logic [31:0]                         access_address,
	output logic [15:0]                         write_value,
	output logic [31:0]                         usable_start,
	output logic [32:0]                         usable_size,
	output logic                                last
);

	msp_pkg::cfg_t  cfg_q;
	msp_pkg::push_t push;
	msp_pkg::rsp_t  head;

	// input register
	logic        valid_s1;
	logic        command_s1;
	logic [15:0] read_data_s1;

	logic room;
	logic consume;
	logic in_fire;

	// configuration registers: write only while idle, the block does not check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_address <= msp_pkg::MIN_START;
			cfg_q.grain_size    <= msp_pkg::RESET_GRAIN;
			cfg_q.kernel_end    <= msp_pkg::MIN_START;
		end else if (cfg_write) begin
			case (cfg_index)
				msp_pkg::REG_START:      cfg_q.start_address <= cfg_data;
				msp_pkg::REG_GRAIN:      cfg_q.grain_size    <= cfg_data;
				msp_pkg::REG_KERNEL_END: cfg_q.kernel_end    <= cfg_data;
				default: begin
					// index past the register list: write is ignored
				end
			endcase
		end
	end

	// the held request moves into the core once the queue has room for two
	assign consume  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			command_s1   <= command;
			read_data_s1 <= read_data;
		end
	end

	// phase sequencer and result forming
	msp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (consume),
		.command   (command_s1),
		.read_data (read_data_s1),
		.cfg       (cfg_q),
		.push      (push)
	);

	// results wait here until the output side takes them
	msp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign request_kind   = head.request_kind;
	assign access_address = head.access_address;
	assign write_value    = head.write_value;
	assign usable_start   = head.usable_start;
	assign usable_size    = head.usable_size;
	assign last           = head.last;

	// a request blocked by a full queue stays put in the input register
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room) |=> (valid_s1 && $stable(command_s1) && $stable(read_data_s1)))
		else $error("held request lost or changed");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	// one request toward the block: start command or memory read response
	typedef struct {
		logic        command;
		logic [15:0] read_data;
		bit          hold_first;   // wait for every due access request before sending
	} probe_cmd_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_write = 1'b0;
	logic [msp_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [31:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic        command   = 1'b0;
	logic [15:0] read_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  request_kind;
	logic [31:0] access_address;
	logic [15:0] write_value;
	logic [31:0] usable_start;
	logic [32:0] usable_size;
	logic        last;

	memory_size_probe_sequencer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.read_data(read_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.request_kind(request_kind),
		.access_address(access_address),
		.write_value(write_value),
		.usable_start(usable_start),
		.usable_size(usable_size),
		.last(last)
	);

	// requests still to be sent, and access requests the block still owes
	probe_cmd_t     cmd_q[$];
	msp_pkg::rsp_t  access_due[$];

	int mismatches = 0;
	int items_made = 0;
	bit quiet      = 1'b0;   // no idling or stalls in the closing stretch
	bit in_flight  = 1'b0;   // an item has left cmd_q but is not yet accepted

	// ---------------------------------------------------------------
	// probe sequencer prediction
	// ---------------------------------------------------------------

	// register copies, at their reset values
	logic [31:0] cfg_start = msp_pkg::MIN_START;
	logic [31:0] cfg_grain = msp_pkg::RESET_GRAIN;
	logic [31:0] cfg_kend  = msp_pkg::MIN_START;

	// probe state
	msp_pkg::phase_t ph    = msp_pkg::PH_IDLE;
	logic [31:0] eff_start = '0;
	logic [31:0] eff_grain = '0;
	logic [32:0] probed    = '0;
	logic [15:0] saved     = '0;

	function automatic msp_pkg::rsp_t access_req(input logic [1:0] kind,
		input logic [31:0] addr, input logic [15:0] val);
		msp_pkg::rsp_t r;
		r = '0;
		r.request_kind = kind;
		r.access_address = addr;
		r.write_value = val;
		return r;
	endfunction

	// the next grain must fit both the 32-bit size and the address space
	function automatic logic grain_fits();
		logic [63:0] span;
		logic [63:0] top;
		span = {31'd0, probed} + {32'd0, eff_grain};
		top = {32'd0, eff_start} + span;
		if (span > 64'h1_0000_0000)
			return 1'b0;
		if (msp_pkg::ADDRESS_BITS >= 64)
			return 1'b1;
		return top <= (64'd1 << msp_pkg::ADDRESS_BITS);
	endfunction

	// head halfword of the grain, or its tail halfword in the tail phases
	function automatic logic [31:0] probe_addr();
		logic [63:0] a;
		a = {32'd0, eff_start} + {31'd0, probed};
		if (ph == msp_pkg::PH_TAIL_OLD || ph == msp_pkg::PH_TAIL_A || ph == msp_pkg::PH_TAIL_B)
			a = a + {32'd0, eff_grain} - 64'd2;
		return a[31:0];
	endfunction

	// done report, with usable memory clipped to begin no lower than the kernel end
	function automatic msp_pkg::rsp_t done_report();
		msp_pkg::rsp_t r;
		logic [63:0] s;
		logic [63:0] z;
		logic [63:0] cut;
		s = {32'd0, eff_start};
		z = {31'd0, probed};
		if (s <= {32'd0, cfg_kend}) begin
			cut = {32'd0, cfg_kend} - s;
			z = (z > cut) ? z - cut : 64'd0;
			s = {32'd0, cfg_kend};
		end
		r = '0;
		r.request_kind = msp_pkg::KIND_DONE;
		r.usable_start = s[31:0];
		r.usable_size = z[32:0];
		ph = msp_pkg::PH_IDLE;
		return r;
	endfunction

	function automatic msp_pkg::rsp_t next_grain_req();
		if (grain_fits()) begin
			ph = msp_pkg::PH_HEAD_OLD;
			return access_req(msp_pkg::KIND_READ, probe_addr(), 16'h0000);
		end
		return done_report();
	endfunction

	// advance the probe on one accepted request and queue what it causes
	task automatic predict_requests(input logic cmd, input logic [15:0] data);
		msp_pkg::rsp_t r [2];
		int n;
		logic [31:0] a;
		n = 0;
		if (cmd == msp_pkg::CMD_START) begin
			eff_start = (cfg_start < msp_pkg::MIN_START) ? msp_pkg::MIN_START : cfg_start;
			eff_grain = (cfg_grain < msp_pkg::MIN_GRAIN) ? msp_pkg::MIN_GRAIN : cfg_grain;
			probed = '0;
			saved = '0;
			r[0] = next_grain_req();
			n = 1;
		end else begin
			a = probe_addr();
			case (ph)
				msp_pkg::PH_HEAD_OLD, msp_pkg::PH_TAIL_OLD: begin
					saved = data;
					r[0] = access_req(msp_pkg::KIND_WRITE, a, msp_pkg::PAT_A);
					r[1] = access_req(msp_pkg::KIND_READ, a, 16'h0000);
					ph = (ph == msp_pkg::PH_HEAD_OLD) ? msp_pkg::PH_HEAD_A : msp_pkg::PH_TAIL_A;
					n = 2;
				end
				msp_pkg::PH_HEAD_A, msp_pkg::PH_TAIL_A: begin
					if (data != msp_pkg::PAT_A) begin
						r[0] = done_report();
						n = 1;
					end else begin
						r[0] = access_req(msp_pkg::KIND_WRITE, a, msp_pkg::PAT_B);
						r[1] = access_req(msp_pkg::KIND_READ, a, 16'h0000);
						ph = (ph == msp_pkg::PH_HEAD_A) ? msp_pkg::PH_HEAD_B : msp_pkg::PH_TAIL_B;
						n = 2;
					end
				end
				msp_pkg::PH_HEAD_B: begin
					if (data != msp_pkg::PAT_B) begin
						r[0] = done_report();
						n = 1;
					end else begin
						r[0] = access_req(msp_pkg::KIND_WRITE, a, saved);
						ph = msp_pkg::PH_TAIL_OLD;
						r[1] = access_req(msp_pkg::KIND_READ, probe_addr(), 16'h0000);
						n = 2;
					end
				end
				msp_pkg::PH_TAIL_B: begin
					if (data != msp_pkg::PAT_B) begin
						r[0] = done_report();
						n = 1;
					end else begin
						r[0] = access_req(msp_pkg::KIND_WRITE, a, saved);
						probed = probed + {1'b0, eff_grain};
						r[1] = next_grain_req();
						n = 2;
					end
				end
				default: ph = msp_pkg::PH_IDLE;
			endcase
		end
		for (int i = 0; i < n; i++) begin
			r[i].last = (i == n - 1);
			access_due.push_back(r[i]);
		end
	endtask

	// ---------------------------------------------------------------
	// clock, reset, watchdog
	// ---------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	// ---------------------------------------------------------------
	// driver: request channel
	// ---------------------------------------------------------------

	probe_cmd_t next_cmd;
	bit         have_next = 1'b0;
	int         gap_left  = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			// a request taken at this edge moves the prediction on
			if (in_valid && in_ready) begin
				predict_requests(command, read_data);
				in_flight = 1'b0;
			end
			// the payload may only change once the current request is gone
			if (!in_valid || in_ready) begin
				if (!have_next && cmd_q.size() != 0) begin
					next_cmd = cmd_q.pop_front();
					have_next = 1'b1;
					in_flight = 1'b1;
				end
				if (have_next && next_cmd.hold_first && access_due.size() != 0) begin
					// hold off until the block has drained everything it owes
					in_valid <= 1'b0;
				end else if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (have_next) begin
					command <= next_cmd.command;
					read_data <= next_cmd.read_data;
					in_valid <= 1'b1;
					have_next = 1'b0;
					if (!quiet && $urandom_range(0, 5) == 0)
						gap_left = $urandom_range(1, 6);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: result channel
	// ---------------------------------------------------------------

	task automatic flag(input string field, input logic [63:0] got, input logic [63:0] want);
		mismatches++;
		$display("mismatch on %s: got %h, want %h at %0t", field, got, want, $time);
	endtask

	msp_pkg::rsp_t want_req;
	int            stall_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (access_due.size() == 0) begin
					flag("request with none due", 64'(request_kind), 64'd0);
				end else begin
					want_req = access_due.pop_front();
					if (request_kind !== want_req.request_kind)
						flag("request_kind", 64'(request_kind), 64'(want_req.request_kind));
					if (access_address !== want_req.access_address)
						flag("access_address", 64'(access_address),
							64'(want_req.access_address));
					if (write_value !== want_req.write_value)
						flag("write_value", 64'(write_value), 64'(want_req.write_value));
					if (usable_start !== want_req.usable_start)
						flag("usable_start", 64'(usable_start), 64'(want_req.usable_start));
					if (usable_size !== want_req.usable_size)
						flag("usable_size", 64'(usable_size), 64'(want_req.usable_size));
					if (last !== want_req.last)
						flag("last", 64'(last), 64'(want_req.last));
				end
			end
			// receiver stalls in random bursts of out_ready low
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	task automatic push_item(input logic cmd, input logic [15:0] data, input bit hold);
		probe_cmd_t c;
		c.command = cmd;
		c.read_data = data;
		c.hold_first = hold;
		cmd_q.push_back(c);
	endtask

	// random hold-offs only while idling is allowed
	function automatic bit rand_hold();
		return !quiet && $urandom_range(0, 39) == 0;
	endfunction

	// start plus well-formed responses for a number of grains: old value,
	// first pattern, second pattern, for head then tail; rare corruption
	// of a check ends the sequence, rare restarts begin it again
	task automatic queue_probe(input int grains);
		logic [15:0] data;
		int step;
		push_item(msp_pkg::CMD_START, 16'($urandom), rand_hold());
		items_made++;
		step = 0;
		while (step < grains * 6) begin
			case (step % 3)
				0: data = 16'($urandom);
				1: data = msp_pkg::PAT_A;
				default: data = msp_pkg::PAT_B;
			endcase
			if ($urandom_range(0, 99) == 0) begin
				// start while busy
				push_item(msp_pkg::CMD_START, 16'($urandom), rand_hold());
				items_made++;
				step = 0;
			end else if (step % 3 != 0 && $urandom_range(0, 49) == 0) begin
				data = data ^ 16'($urandom_range(1, 16'hFFFF));
				push_item(msp_pkg::CMD_RESP, data, rand_hold());
				items_made++;
				return;
			end else begin
				push_item(msp_pkg::CMD_RESP, data, rand_hold());
				items_made++;
				step++;
			end
		end
	endtask

	// block idle: all requests accepted and every result in, then latency
	task automatic settle();
		while (cmd_q.size() != 0 || in_flight || access_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] s, input logic [31:0] g, input logic [31:0] k);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= msp_pkg::REG_START;
		cfg_data <= s;
		@(posedge clk);
		cfg_index <= msp_pkg::REG_GRAIN;
		cfg_data <= g;
		@(posedge clk);
		cfg_index <= msp_pkg::REG_KERNEL_END;
		cfg_data <= k;
		@(posedge clk);
		cfg_write <= 1'b0;
		cfg_start = s;
		cfg_grain = g;
		cfg_kend = k;
	endtask

	initial begin
		logic [31:0] s;
		logic [31:0] g;
		logic [31:0] k;
		logic [31:0] es;
		int grains;
		int phase_no;
		int target;
		int noise;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset register values
		push_item(msp_pkg::CMD_RESP, 16'hFFFF, 1'b0);   // response while idle, ignored
		push_item(msp_pkg::CMD_START, 16'hFFFF, 1'b0);
		push_item(msp_pkg::CMD_RESP, 16'h0000, 1'b0);   // head old value
		push_item(msp_pkg::CMD_RESP, msp_pkg::PAT_A, 1'b0);
		push_item(msp_pkg::CMD_RESP, msp_pkg::PAT_B, 1'b0);  // restore head, read tail
		push_item(msp_pkg::CMD_RESP, 16'hFFFF, 1'b0);   // tail old value
		push_item(msp_pkg::CMD_RESP, msp_pkg::PAT_A, 1'b0);
		push_item(msp_pkg::CMD_RESP, msp_pkg::PAT_B, 1'b0);  // restore tail, next grain
		push_item(msp_pkg::CMD_RESP, 16'h1234, 1'b0);
		push_item(msp_pkg::CMD_RESP, 16'h0000, 1'b0);   // mismatch on the first pattern of a head
		push_item(msp_pkg::CMD_START, 16'h0000, 1'b1);  // waits for every due result first
		push_item(msp_pkg::CMD_RESP, 16'h8001, 1'b0);
		push_item(msp_pkg::CMD_RESP, msp_pkg::PAT_A, 1'b0);
		push_item(msp_pkg::CMD_RESP, msp_pkg::PAT_A, 1'b0);  // mismatch on the second pattern of a head
		push_item(msp_pkg::CMD_START, 16'h5A5A, 1'b0);
		push_item(msp_pkg::CMD_RESP, 16'h7FFE, 1'b0);
		push_item(msp_pkg::CMD_RESP, msp_pkg::PAT_A, 1'b0);
		push_item(msp_pkg::CMD_RESP, msp_pkg::PAT_B, 1'b0);
		push_item(msp_pkg::CMD_RESP, 16'hC3C3, 1'b0);
		push_item(msp_pkg::CMD_RESP, msp_pkg::PAT_B, 1'b0);  // mismatch on the first pattern of a tail
		push_item(msp_pkg::CMD_START, 16'h0001, 1'b0);
		push_item(msp_pkg::CMD_START, 16'hFFFE, 1'b0);  // start while busy
		push_item(msp_pkg::CMD_RESP, 16'hABCD, 1'b0);
		push_item(msp_pkg::CMD_RESP, msp_pkg::PAT_A, 1'b0);
		push_item(msp_pkg::CMD_RESP, msp_pkg::PAT_B, 1'b0);
		push_item(msp_pkg::CMD_RESP, 16'h2468, 1'b0);
		push_item(msp_pkg::CMD_RESP, msp_pkg::PAT_A, 1'b0);
		push_item(msp_pkg::CMD_RESP, 16'h0000, 1'b0);   // mismatch on the second pattern of a tail
		items_made = 28;
		settle();

		// register settings: extremes first, then random ones
		phase_no = 0;
		while (items_made < 1900) begin
			if (items_made > 1650)
				quiet = 1'b1;
			case (phase_no)
				0: begin  // both raised to their floors, kernel end below start
					s = 32'h0; g = 32'h0; k = 32'h0; grains = 2;
				end
				1: begin  // no grain fits at all
					s = 32'hFFFF_FFFF; g = 32'h8000_0000; k = 32'hFFFF_FFFF; grains = 1;
				end
				2: begin  // largest grain, one fits
					s = msp_pkg::MIN_START; g = 32'h8000_0000; k = msp_pkg::MIN_START;
					grains = 3;
				end
				3: begin  // last grain ends exactly at the top of the address space
					s = 32'hFFFF_FF00; g = 32'h100; k = 32'hFFFF_FFFF; grains = 2;
				end
				4: begin
					s = 32'hFFFF_FFFF; g = 32'h0; k = 32'h0; grains = 1;
				end
				default: begin
					case ($urandom_range(0, 3))
						0: begin
							g = $urandom_range(256, 8192);
							s = $urandom_range(32'h0010_0000, 32'h4000_0000);
							grains = 3;
						end
						1: begin  // near the top, runs out of address space
							g = 32'h100 << $urandom_range(0, 8);
							s = 32'hFFFF_FFFF - g * $urandom_range(0, 4) - $urandom_range(0, g);
							grains = 6;
						end
						2: begin  // huge grains, runs out of address space
							g = $urandom_range(32'h2000_0000, 32'h8000_0000);
							s = $urandom_range(0, 32'h1000_0000);
							grains = 5;
						end
						default: begin  // below both floors
							s = $urandom_range(0, 32'h000F_FFFF);
							g = $urandom_range(0, 255);
							grains = 2;
						end
					endcase
					es = (s < msp_pkg::MIN_START) ? msp_pkg::MIN_START : s;
					case ($urandom_range(0, 4))
						0: k = 32'h0;
						1: k = 32'hFFFF_FFFF;
						2: k = es + $urandom_range(0,
							3 * ((g < msp_pkg::MIN_GRAIN) ? msp_pkg::MIN_GRAIN : g));
						3: k = es - $urandom_range(0, 4096);
						default: k = $urandom;
					endcase
				end
			endcase
			configure(s, g, k);
			target = items_made + $urandom_range(60, 160);
			while (items_made < target) begin
				queue_probe($urandom_range(1, grains));
				// stray responses, mostly hitting an idle block
				if ($urandom_range(0, 3) == 0) begin
					noise = $urandom_range(1, 3);
					repeat (noise) push_item(msp_pkg::CMD_RESP, 16'($urandom), 1'b0);
				end
			end
			settle();
			phase_no++;
		end

		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

>>> files.f
rtl/msp_pkg.sv
rtl/msp_core.sv
rtl/msp_outq.sv
rtl/memory_size_probe_sequencer_top.sv
tb/sv/testbench.sv
